// File: hw/rtl/ucal_pkg.sv
// Package: constants and tables for the seconds-to-calendar-date pipeline.
`timescale 1ns / 1ps

package ucal_pkg;

    localparam int SECS_W  = 32;
    localparam int DATE_W  = 27;
    localparam int LATENCY = 9;

    // Reciprocal multipliers for exact constant division (round-up method).
    localparam logic [25:0] DIV675_MUL   = 26'd50903317;
    localparam int          DIV675_SHIFT = 35;
    localparam logic [16:0] DIV365A_MUL  = 17'd91930;
    localparam int          DIV365A_SHIFT = 25;
    localparam logic [18:0] DIV365B_MUL  = 19'd367720;
    localparam int          DIV365B_SHIFT = 27;
    localparam logic [11:0] DIV153_MUL   = 12'd3427;
    localparam int          DIV153_SHIFT = 19;

    localparam logic [19:0] SHIFT_TO_MARCH0 = 20'd719468;
    localparam logic [19:0] DAYS_PER_ERA    = 20'd146097;
    localparam logic [17:0] DAYS_PER_ERA_M1 = 18'd146096;
    localparam logic [17:0] DAYS_PER_100Y_M1 = 18'd36524;
    localparam logic [13:0] YEAR_LIMIT      = 14'd9999;

    function automatic logic [19:0] era_base(input logic [2:0] era);
        logic [19:0] base;
        case (era)
            3'd1:    base = 20'd146097;
            3'd2:    base = 20'd292194;
            3'd3:    base = 20'd438291;
            3'd4:    base = 20'd584388;
            3'd5:    base = 20'd730485;
            default: base = 20'd0;
        endcase
        return base;
    endfunction

    // (153 * mp + 2) / 5: first day of each March-based month within the year
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            4'd12:   off = 9'd367;
            4'd13:   off = 9'd398;
            4'd14:   off = 9'd428;
            4'd15:   off = 9'd459;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: hw/rtl/unix_seconds_to_calendar_date.sv
// done is registered from the last stage valid bit, alongside the date and date_ok registers.
// Throughput: one item per cycle; busy stays low, a nine-stage pipeline with no stall.
// Each result shows for one cycle on done; the receiver cannot hold it off.
// Reset (rst_n low, asynchronous) clears all stage valid bits and done.
// Data registers are not reset.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date
    import ucal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [SECS_W-1:0] epoch_seconds,
    output logic              done,
    output logic [DATE_W-1:0] date_decimal,
    output logic              date_ok
);

    logic [LATENCY-2:0] vld_reg;
    logic [LATENCY-2:0] vld_next;
    logic               done_reg;

    // stage 1: days = secs / 86400 as (secs >> 7) / 675
    logic [50:0] s1_prod_reg, s1_prod_next;
    // stage 2
    logic [19:0] s2_shifted_reg, s2_shifted_next;
    // stage 3
    logic [2:0]  s3_era_reg, s3_era_next;
    logic [17:0] s3_doe_reg, s3_doe_next;
    // stage 4
    logic [2:0]  s4_era_reg;
    logic [17:0] s4_doe_reg;
    logic [17:0] s4_num_reg, s4_num_next;
    // stage 5
    logic [2:0]  s5_era_reg;
    logic [17:0] s5_doe_reg;
    logic [8:0]  s5_yoe_reg, s5_yoe_next;
    // stage 6
    logic [2:0]  s6_era_reg;
    logic [8:0]  s6_yoe_reg;
    logic [8:0]  s6_doy_reg, s6_doy_next;
    // stage 7
    logic [2:0]  s7_era_reg;
    logic [8:0]  s7_yoe_reg;
    logic [8:0]  s7_doy_reg;
    logic [3:0]  s7_mp_reg, s7_mp_next;
    // stage 8
    logic [13:0] s8_yr_reg, s8_yr_next;
    logic [3:0]  s8_mon_reg, s8_mon_next;
    logic [8:0]  s8_dom_reg, s8_dom_next;
    // output
    logic [DATE_W-1:0] date_reg, date_next;
    logic              ok_reg, ok_next;

    logic        accept;
    logic [15:0] dayno;
    logic [2:0]  q100y;
    logic [6:0]  q4y;
    logic        q_era;
    logic [32:0] p1460;
    logic [36:0] p365;
    logic [17:0] yoe_days;
    logic [1:0]  q100;
    logic [10:0] mp_num;
    logic [22:0] p153;
    logic [3:0]  mon;
    logic [8:0]  off;
    logic [11:0] era_years;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        vld_next = {vld_reg[LATENCY-3:0], accept};

        s1_prod_next = 51'(epoch_seconds[SECS_W-1:7]) * 51'(DIV675_MUL);

        dayno           = s1_prod_reg[DIV675_SHIFT +: 16];
        s2_shifted_next = 20'(dayno) + SHIFT_TO_MARCH0;

        s3_era_next = 3'(s2_shifted_reg >= DAYS_PER_ERA)
                    + 3'(s2_shifted_reg >= 20'd292194)
                    + 3'(s2_shifted_reg >= 20'd438291)
                    + 3'(s2_shifted_reg >= 20'd584388)
                    + 3'(s2_shifted_reg >= 20'd730485);
        s3_doe_next = 18'(s2_shifted_reg - era_base(s3_era_next));

        q100y = 3'(s3_doe_reg >= DAYS_PER_100Y_M1)
              + 3'(s3_doe_reg >= 18'd73048)
              + 3'(s3_doe_reg >= 18'd109572)
              + 3'(s3_doe_reg >= DAYS_PER_ERA_M1);
        q_era = (s3_doe_reg == DAYS_PER_ERA_M1);
        p1460 = 33'(s3_doe_reg[17:2]) * 33'(DIV365A_MUL);
        q4y   = p1460[DIV365A_SHIFT +: 7];
        s4_num_next = s3_doe_reg + 18'(q100y) - 18'(q4y) - 18'(q_era);

        p365        = 37'(s4_num_reg) * 37'(DIV365B_MUL);
        s5_yoe_next = p365[DIV365B_SHIFT +: 9];

        q100 = 2'(s5_yoe_reg >= 9'd100) + 2'(s5_yoe_reg >= 9'd200)
             + 2'(s5_yoe_reg >= 9'd300);
        yoe_days = 18'(s5_yoe_reg) * 18'd365 + 18'(s5_yoe_reg[8:2]) - 18'(q100);
        s6_doy_next = 9'(s5_doe_reg - yoe_days);

        mp_num     = 11'(s6_doy_reg) * 11'd5 + 11'd2;
        p153       = 23'(mp_num) * 23'(DIV153_MUL);
        s7_mp_next = p153[DIV153_SHIFT +: 4];

        off         = month_offset(s7_mp_reg);
        s8_dom_next = s7_doy_reg - off + 9'd1;
        mon         = (s7_mp_reg < 4'd10) ? (s7_mp_reg + 4'd3) : (s7_mp_reg - 4'd9);
        s8_mon_next = mon;
        era_years   = 12'(s7_era_reg) * 12'd400;
        s8_yr_next  = 14'(era_years) + 14'(s7_yoe_reg) + 14'(mon <= 4'd2);

        ok_next = (s8_yr_reg <= YEAR_LIMIT) && (s8_mon_reg != 4'd0)
               && (s8_mon_reg <= 4'd12) && (s8_dom_reg != 9'd0)
               && (s8_dom_reg <= 9'd31);
        date_next = ok_next
                  ? (DATE_W'(s8_yr_reg) * DATE_W'(10000) + DATE_W'(s8_mon_reg) * DATE_W'(100)
                     + DATE_W'(s8_dom_reg))
                  : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[LATENCY-2];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg    <= s1_prod_next;
        s2_shifted_reg <= s2_shifted_next;
        s3_era_reg     <= s3_era_next;
        s3_doe_reg     <= s3_doe_next;
        s4_era_reg     <= s3_era_reg;
        s4_doe_reg     <= s3_doe_reg;
        s4_num_reg     <= s4_num_next;
        s5_era_reg     <= s4_era_reg;
        s5_doe_reg     <= s4_doe_reg;
        s5_yoe_reg     <= s5_yoe_next;
        s6_era_reg     <= s5_era_reg;
        s6_yoe_reg     <= s5_yoe_reg;
        s6_doy_reg     <= s6_doy_next;
        s7_era_reg     <= s6_era_reg;
        s7_yoe_reg     <= s6_yoe_reg;
        s7_doy_reg     <= s6_doy_reg;
        s7_mp_reg      <= s7_mp_next;
        s8_yr_reg      <= s8_yr_next;
        s8_mon_reg     <= s8_mon_next;
        s8_dom_reg     <= s8_dom_next;
        date_reg       <= date_next;
        ok_reg         <= ok_next;
    end

    assign done         = done_reg;
    assign date_decimal = date_reg;
    assign date_ok      = ok_reg;

`ifndef SYNTHESIS
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item produced no result");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !date_ok) |-> (date_decimal == '0))
        else $error("invalid date not zeroed");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_ok) |-> (date_decimal != '0))
        else $error("valid date reads as zero");
`endif

endmodule

// File: tb/unix_seconds_to_calendar_date_tb.sv
// Testbench: Unix seconds to calendar date pipeline, directed and random items checked in order.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_tb;
    import ucal_pkg::*;

    localparam int unsigned SECS_PER_DAY     = 86400;
    localparam int unsigned MARCH0_OFFSET    = 719468;
    localparam int unsigned ERA_DAYS         = 146097;
    localparam int unsigned LEAP4_DAYS_M1    = 1460;
    localparam int unsigned CENT_DAYS_M1     = 36524;
    localparam int unsigned ERA_DAYS_M1      = 146096;
    localparam int unsigned YEAR_DAYS        = 365;
    localparam int unsigned MONTH_SPAN       = 153;
    localparam int unsigned MAX_YEAR         = 9999;
    localparam int unsigned LAST_DAY_NO      = 49710;
    localparam int          MAX_REPORTS      = 10;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic              ok;
    } cal_date_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [SECS_W-1:0] epoch_seconds = '0;
    logic              busy;
    logic              done;
    logic [DATE_W-1:0] date_decimal;
    logic              date_ok;

    cal_date_t pending_dates[$];
    int        mismatch_cnt = 0;
    int        burst_left = 0;

    unix_seconds_to_calendar_date DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .date_decimal  (date_decimal),
        .date_ok       (date_ok)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic cal_date_t calendar_date_of(input logic [SECS_W-1:0] secs);
        int unsigned days, shifted, era, doe, yoe, yr, doy, mp, dom, mon;
        cal_date_t   res;
        days    = secs / SECS_PER_DAY;
        shifted = days + MARCH0_OFFSET;
        era     = shifted / ERA_DAYS;
        doe     = shifted - era * ERA_DAYS;
        yoe     = (doe - doe / LEAP4_DAYS_M1 + doe / CENT_DAYS_M1 - doe / ERA_DAYS_M1)
                  / YEAR_DAYS;
        yr      = yoe + era * 400;
        doy     = doe - (YEAR_DAYS * yoe + yoe / 4 - yoe / 100);
        mp      = (5 * doy + 2) / MONTH_SPAN;
        dom     = doy - (MONTH_SPAN * mp + 2) / 5 + 1;
        mon     = (mp < 10) ? mp + 3 : mp - 9;
        if (mon <= 2)
        begin
            yr = yr + 1;
        end
        if (yr > MAX_YEAR || mon == 0 || mon > 12 || dom == 0 || dom > 31)
        begin
            res.date = '0;
            res.ok   = 1'b0;
        end
        else
        begin
            res.date = DATE_W'(yr * 10000 + mon * 100 + dom);
            res.ok   = 1'b1;
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the item, start left high.
    task automatic send_item(input logic [SECS_W-1:0] secs);
        start         <= 1'b1;
        epoch_seconds <= secs;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_dates.push_back(calendar_date_of(secs));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Bursts of random length separated by random gaps.
    task automatic send_paced(input logic [SECS_W-1:0] secs);
        if (burst_left == 0)
        begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        send_item(secs);
        burst_left--;
    endtask

    always @(posedge clk)
    begin
        cal_date_t want;
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result date=%0d ok=%0b",
                             $realtime, date_decimal, date_ok);
            end
            else
            begin
                want = pending_dates.pop_front();
                if (date_decimal !== want.date || date_ok !== want.ok)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: date exp %0d got %0d, ok exp %0b got %0b",
                                 $realtime, want.date, date_decimal, want.ok, date_ok);
                end
            end
        end
    end

    task automatic test_directed();
        logic [SECS_W-1:0] vals[$];
        vals = '{32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400,
                 32'd68169599, 32'd68169600, 32'd68255999,
                 32'd946684799, 32'd946684800,
                 32'd951782399, 32'd951782400, 32'd951868800,
                 32'd2147483647, 32'd2147483648,
                 32'd4107455999, 32'd4107542400,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
                 32'd4294944000, 32'd4294943999};
        foreach (vals[i])
            send_paced(vals[i]);
    endtask

    task automatic test_random_seconds(input int n);
        repeat (n) send_paced($urandom);
    endtask

    // Last second of a day followed by the first second of the next.
    task automatic test_day_edges(input int n);
        int unsigned d;
        repeat (n)
        begin
            d = $urandom_range(1, LAST_DAY_NO);
            send_paced(d * SECS_PER_DAY - 1);
            send_paced(d * SECS_PER_DAY);
        end
    endtask

    task automatic test_back_to_back(input int n);
        repeat (n) send_item($urandom);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_seconds(1000);
        test_day_edges(200);
        test_back_to_back(300);
        idle_cycles(1);
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
